@@ hdl/cpwp_pkg.sv @@
package cpwp_pkg;

  // tape memory geometry
  localparam int TAPE_DEPTH = 65536;
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);

  // field and register widths
  localparam int POS_W    = 17;
  localparam int POLL_W   = 15;
  localparam int PER_W    = 6;
  localparam int MARGIN_W = 16;
  localparam int BITS_W   = 4;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 17;

  localparam logic [POLL_W-1:0] POLL_MAX    = '1;
  localparam logic [7:0]        PORT_LOW    = 8'hEF;
  localparam logic [7:0]        PORT_HIGH   = 8'hFF;
  localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd9;

  // reset values of the configuration registers
  localparam logic [POS_W-1:0]    FILE_SIZE_RST  = '0;
  localparam logic [POLL_W-1:0]   THRESHOLD_RST  = 15'd20000;
  localparam logic [PER_W-1:0]    SHORT_RST      = 6'd8;
  localparam logic [PER_W-1:0]    LONG_RST       = 6'd24;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 16'd512;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_FILE_SIZE   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SHORT       = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LONG        = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MARGIN      = 3'd4;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MOTOR_STOP   = 2'd0,
    MOTOR_NORMAL = 2'd1,
    MOTOR_AUTO   = 2'd2
  } motor_t;

  typedef struct packed {
    logic [POS_W-1:0]    file_size;
    logic [POLL_W-1:0]   play_threshold;
    logic [PER_W-1:0]    short_period;
    logic [PER_W-1:0]    long_period;
    logic [MARGIN_W-1:0] near_end_margin;
  } cfg_t;

  // result of one word as seen after it has been processed
  typedef struct packed {
    logic [7:0] port_value;
    motor_t     motor;
    logic       fast_load;
    logic       end_of_tape;
  } result_t;

endpackage

@@ hdl/cpwp_tape_mem.sv @@
module cpwp_tape_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [cpwp_pkg::TAPE_AW-1:0] wr_addr,
  input  logic [7:0]                  wr_data,
  input  logic                        rd_en,
  input  logic [cpwp_pkg::TAPE_AW-1:0] rd_addr,
  output logic [7:0]                  rd_data
);
  import cpwp_pkg::*;

  logic [7:0] mem [TAPE_DEPTH];

  // single write port, registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/cpwp_player.sv @@
module cpwp_player (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          is_read,
  input  cpwp_pkg::cfg_t                cfg,
  input  logic [7:0]                    rd_data,
  output logic [cpwp_pkg::TAPE_AW-1:0]  fetch_addr,
  output cpwp_pkg::result_t             res
);
  import cpwp_pkg::*;

  logic [POS_W-1:0]  tape_position, tape_position_next;
  motor_t            motor_state, motor_state_next;
  logic              speedup_flag, speedup_flag_next;
  logic              eof_flag, eof_flag_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [BITS_W-1:0] bits_left, bits_left_next;
  logic [PER_W-1:0]  pulse_period, pulse_period_next;
  logic [PER_W-1:0]  pulse_count, pulse_count_next;
  logic [POLL_W-1:0] poll_count, poll_count_next;
  logic [7:0]        port_next;

  assign fetch_addr = tape_position[TAPE_AW-1:0];

  // one port read worth of playback
  always_comb begin
    logic [POS_W:0] near_sum;
    tape_position_next = tape_position;
    motor_state_next   = motor_state;
    speedup_flag_next  = speedup_flag;
    eof_flag_next      = eof_flag;
    shift_byte_next    = shift_byte;
    bits_left_next     = bits_left;
    pulse_period_next  = pulse_period;
    pulse_count_next   = pulse_count;
    port_next          = PORT_HIGH;
    near_sum = {1'b0, tape_position} + {{(POS_W + 1 - MARGIN_W){1'b0}}, cfg.near_end_margin};

    poll_count_next = (poll_count < POLL_MAX) ? poll_count + 1'b1 : poll_count;
    if (poll_count_next > cfg.play_threshold && motor_state == MOTOR_STOP) begin
      motor_state_next = MOTOR_AUTO;
    end

    if (motor_state_next != MOTOR_STOP) begin
      priority if (bits_left == '0 && tape_position >= cfg.file_size) begin
        // tape ran out
        bits_left_next    = BITS_PER_BYTE;
        pulse_period_next = '0;
        pulse_count_next  = '0;
        eof_flag_next     = 1'b1;
        motor_state_next  = MOTOR_STOP;
        speedup_flag_next = 1'b0;
        shift_byte_next   = '0;
        port_next         = PORT_LOW;
      end else begin
        if (bits_left == '0) begin
          // fetch next byte
          bits_left_next    = BITS_PER_BYTE;
          pulse_period_next = '0;
          pulse_count_next  = '0;
          if (near_sum >= {1'b0, cfg.file_size}) begin
            motor_state_next  = MOTOR_NORMAL;
            speedup_flag_next = 1'b0;
          end
          shift_byte_next    = rd_data;
          tape_position_next = tape_position + 1'b1;
        end
        // start of a new pulse
        if (pulse_count_next >= pulse_period_next) begin
          pulse_period_next = shift_byte_next[0] ? cfg.short_period : cfg.long_period;
          pulse_count_next  = '0;
          shift_byte_next   = shift_byte_next >> 1;
          bits_left_next    = bits_left_next - 1'b1;
        end
        // low half then high half
        port_next = (pulse_count_next < (pulse_period_next >> 1)) ? PORT_LOW : PORT_HIGH;
        pulse_count_next = pulse_count_next + 1'b1;
      end
    end
  end

  // result of the word in flight
  always_comb begin
    if (is_read) begin
      res.port_value  = port_next;
      res.motor       = motor_state_next;
      res.fast_load   = speedup_flag_next;
      res.end_of_tape = eof_flag_next;
    end else begin
      res.port_value  = PORT_HIGH;
      res.motor       = motor_state;
      res.fast_load   = speedup_flag;
      res.end_of_tape = eof_flag;
    end
  end

  // playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      tape_position <= '0;
      motor_state   <= MOTOR_STOP;
      speedup_flag  <= 1'b1;
      eof_flag      <= 1'b0;
      shift_byte    <= '0;
      bits_left     <= '0;
      pulse_period  <= '0;
      pulse_count   <= '0;
      poll_count    <= '0;
    end else if (step && is_read) begin
      tape_position <= tape_position_next;
      motor_state   <= motor_state_next;
      speedup_flag  <= speedup_flag_next;
      eof_flag      <= eof_flag_next;
      shift_byte    <= shift_byte_next;
      bits_left     <= bits_left_next;
      pulse_period  <= pulse_period_next;
      pulse_count   <= pulse_count_next;
      poll_count    <= poll_count_next;
    end
  end

endmodule

@@ hdl/cassette_pulse_width_playback_unit.sv @@
// Cassette playback unit: each input word is either a tape byte write (opcode 0)
// into the on-chip tape memory or a port read (opcode 1) that returns 0xEF or 0xFF
// as the next sample of the pulse-width tape waveform, together with the motor mode,
// fast-load flag and end-of-tape flag after that read. Every word gives exactly one
// result word. A word first reads the synchronous tape memory at the current tape
// position (a write word writes it instead), then updates the playback state and
// loads the output register. A new word is taken only once the one before it has
// left the update step, which waits while a stalled result is held. The output
// register lets the next word enter while a result still waits. Tape memory is
// not cleared by reset and needs no clearing pass; bytes up to file_size must be
// written before playback. Configuration writes are taken at any edge with
// cfg_write high and must only be issued while no word is in flight.
module cassette_pulse_width_playback_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [cpwp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cpwp_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [15:0]                 load_address,
  input  logic [7:0]                  load_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  port_value,
  output logic [1:0]                  motor_mode,
  output logic                        fast_load,
  output logic                        end_of_tape
);
  import cpwp_pkg::*;

  cfg_t             cfg;
  logic             accept;
  logic             b_valid;
  op_t              b_op;
  logic             fire;
  logic [7:0]       rd_data;
  logic [TAPE_AW-1:0] fetch_addr;
  result_t          res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_size       <= FILE_SIZE_RST;
      cfg.play_threshold  <= THRESHOLD_RST;
      cfg.short_period    <= SHORT_RST;
      cfg.long_period     <= LONG_RST;
      cfg.near_end_margin <= MARGIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FILE_SIZE: cfg.file_size       <= cfg_data[POS_W-1:0];
        CFG_THRESHOLD: cfg.play_threshold  <= cfg_data[POLL_W-1:0];
        CFG_SHORT:     cfg.short_period    <= cfg_data[PER_W-1:0];
        CFG_LONG:      cfg.long_period     <= cfg_data[PER_W-1:0];
        CFG_MARGIN:    cfg.near_end_margin <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // word handshake: one word in the update stage at a time
  assign in_stall = b_valid;
  assign accept   = in_valid && !b_valid;
  assign fire     = b_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_op <= op_t'(opcode);
    end
  end

  cpwp_tape_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && op_t'(opcode) == OP_WRITE),
    .wr_addr (load_address[TAPE_AW-1:0]),
    .wr_data (load_data),
    .rd_en   (accept && op_t'(opcode) == OP_READ),
    .rd_addr (fetch_addr),
    .rd_data (rd_data)
  );

  cpwp_player u_player (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .is_read    (b_op == OP_READ),
    .cfg        (cfg),
    .rd_data    (rd_data),
    .fetch_addr (fetch_addr),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      port_value  <= res.port_value;
      motor_mode  <= res.motor;
      fast_load   <= res.fast_load;
      end_of_tape <= res.end_of_tape;
    end
  end

endmodule

@@ hdl/cpwp_checker.sv @@
module cpwp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] port_value,
  input logic [1:0] motor_mode,
  input logic       fast_load,
  input logic       end_of_tape
);
  import cpwp_pkg::*;

  // no word is accepted right after another
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted in back-to-back cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(port_value) && $stable(motor_mode)))
    else $error("stalled result changed");

  // end of tape always clears fast load
  a_eof_slow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_tape) |-> !fast_load)
    else $error("fast load still set at end of tape");

  // near end mode always clears fast load
  a_normal_slow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motor_mode == MOTOR_NORMAL) |-> !fast_load)
    else $error("fast load set in normal motor mode");

  // port only shows the two legal levels
  a_port_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (port_value == PORT_LOW || port_value == PORT_HIGH))
    else $error("illegal port value");

endmodule

bind cassette_pulse_width_playback_unit cpwp_checker u_cpwp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .port_value  (port_value),
  .motor_mode  (motor_mode),
  .fast_load   (fast_load),
  .end_of_tape (end_of_tape)
);
